// File: src/rv32i_instruction_step_unit_defines.svh
`ifndef RV32I_INSTRUCTION_STEP_UNIT_DEFINES_SVH
`define RV32I_INSTRUCTION_STEP_UNIT_DEFINES_SVH

// condition holds at every edge out of reset
`define RVS_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// consequent holds in the same cycle
`define RVS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) else $error(msg);

// consequent holds in the next cycle
`define RVS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/rvstep_pkg.sv
package rvstep_pkg;

    localparam int MEM_BYTES_DEFAULT = 65536;
    localparam logic [31:0] HALT_WORD_RESET = 32'h0ff00513;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] F7_BASE    = 7'h00;
    localparam logic [6:0] F7_ALT     = 7'h20;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_HALT     = 3'd1,
        STS_PC_RANGE = 3'd2,
        STS_ILLEGAL  = 3'd3,
        STS_ACCESS   = 3'd4,
        STS_MISALIGN = 3'd5,
        STS_STOPPED  = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_LOADWB
    } state_t;

    typedef struct packed {
        logic        is_step;
        logic [15:0] addr;
        logic [7:0]  data;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] pc_after;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic [7:0]  exit_code;
    } res_t;

    function automatic logic [31:0] gather_bytes(input logic [1:0] lo, input logic [31:0] lanes);
        logic [31:0] v;
        logic [1:0]  l;
        v = '0;
        for (int k = 0; k < 4; k++) begin
            l = lo + 2'(k);
            v[8*k +: 8] = lanes[{l, 3'b000} +: 8];
        end
        return v;
    endfunction

endpackage

// File: src/rv32i_instruction_step_unit.sv
// Back end answers a byte load, a stopped step or a pc out of range in idle, a halt word in
// fetch, other steps in execute and a data load in load write-back; fetch, register read and
// load data each take one registered read of the byte-lane or register-file memories.
// Reset: synchronous, active low; a clearing pass then zeroes the byte memory one word
// a cycle across all MEM_BYTES/4 rows, with s_ready low until it ends.
module rv32i_instruction_step_unit #(
    parameter int MEM_BYTES = rvstep_pkg::MEM_BYTES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [15:0] s_load_addr,
    input  logic [7:0]  s_load_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_pc_after,
    output logic        m_reg_write,
    output logic [4:0]  m_reg_index,
    output logic [31:0] m_reg_value,
    output logic [7:0]  m_exit_code
);
    import rvstep_pkg::*;

    logic [31:0] halt_reg;
    item_t       item;
    logic        item_valid;
    logic        item_pop;
    logic        accept_en;
    res_t        res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halt_reg <= HALT_WORD_RESET;
        end else if (cfg_wr_en) begin
            halt_reg <= cfg_wr_data;
        end
    end

    rvstep_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_load_addr (s_load_addr),
        .s_load_byte (s_load_byte),
        .accept_en   (accept_en),
        .item        (item),
        .item_valid  (item_valid),
        .item_pop    (item_pop)
    );

    rvstep_back #(.MEM_BYTES(MEM_BYTES)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .halt_word  (halt_reg),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .accept_en  (accept_en),
        .m_ready    (m_ready),
        .res        (res),
        .res_valid  (m_valid)
    );

    assign m_status    = res.status;
    assign m_pc_after  = res.pc_after;
    assign m_reg_write = res.reg_write;
    assign m_reg_index = res.reg_index;
    assign m_reg_value = res.reg_value;
    assign m_exit_code = res.exit_code;
endmodule

// File: src/rvstep_ram.sv
module rvstep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: src/rvstep_front.sv
module rvstep_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    input  logic [15:0]         s_load_addr,
    input  logic [7:0]          s_load_byte,
    input  logic                accept_en,
    output rvstep_pkg::item_t   item,
    output logic                item_valid,
    input  logic                item_pop
);
    import rvstep_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);

    item_t         q_reg [QUEUE_DEPTH];
    logic [QW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QW:0]   count_reg, count_next;
    logic          push;
    logic          pop;

    assign s_ready    = accept_en && (count_reg < (QW+1)'(QUEUE_DEPTH));
    assign push       = s_valid && s_ready;
    assign item_valid = (count_reg != '0);
    assign pop        = item_pop && item_valid;
    assign item       = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= '{is_step: s_req_type, addr: s_load_addr, data: s_load_byte};
        end
    end
endmodule

// File: src/rvstep_back.sv
`include "rv32i_instruction_step_unit_defines.svh"

module rvstep_back #(
    parameter int MEM_BYTES = rvstep_pkg::MEM_BYTES_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [31:0]       halt_word,
    input  rvstep_pkg::item_t item,
    input  logic              item_valid,
    output logic              item_pop,
    output logic              accept_en,
    input  logic              m_ready,
    output rvstep_pkg::res_t  res,
    output logic              res_valid
);
    import rvstep_pkg::*;

    localparam int ROWS = MEM_BYTES / 4;
    localparam int RW   = $clog2(ROWS);

    state_t        state_reg, state_next;
    logic [31:0]   pc_reg, pc_next;
    logic          stopped_reg, stopped_next;
    logic [RW-1:0] clr_reg, clr_next;
    logic [31:0]   inst_reg, inst_next;
    logic [31:0]   valid_reg, valid_next;
    logic [7:0]    x10_reg, x10_next;
    logic [2:0]    ld_f3_reg, ld_f3_next;
    logic [1:0]    ld_lo_reg, ld_lo_next;
    res_t          res_reg, res_next;
    logic          res_valid_reg, res_valid_next;

    logic          lane_we    [4];
    logic [RW-1:0] lane_waddr [4];
    logic [7:0]    lane_wdata [4];
    logic [RW-1:0] lane_raddr [4];
    logic [7:0]    lane_rdata [4];
    logic [31:0]   lanes_q;

    logic          rf_we;
    logic [4:0]    rf_waddr;
    logic [31:0]   rf_wdata;
    logic [4:0]    rf_ra1, rf_ra2;
    logic [31:0]   rf_q1, rf_q2;

    for (genvar i = 0; i < 4; i++) begin : g_lane
        rvstep_ram #(.WIDTH(8), .DEPTH(ROWS)) u_lane (
            .aclk  (aclk),
            .we    (lane_we[i]),
            .waddr (lane_waddr[i]),
            .wdata (lane_wdata[i]),
            .raddr (lane_raddr[i]),
            .rdata (lane_rdata[i])
        );
        assign lanes_q[8*i +: 8] = lane_rdata[i];
    end

    rvstep_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
        .aclk (aclk), .we (rf_we), .waddr (rf_waddr), .wdata (rf_wdata),
        .raddr (rf_ra1), .rdata (rf_q1)
    );
    rvstep_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
        .aclk (aclk), .we (rf_we), .waddr (rf_waddr), .wdata (rf_wdata),
        .raddr (rf_ra2), .rdata (rf_q2)
    );

    // execute-stage decode
    logic [6:0]  opc, f7;
    logic [2:0]  f3;
    logic [4:0]  rd, sh;
    logic [31:0] a, b, op2, immi, imms, immb, immj, immu;
    logic [31:0] sum_ai, alu, mem_addr, ex_val, ex_next_pc, pc4;
    logic [32:0] mem_end;
    logic [1:0]  sz;
    logic        lt_s, lt_u, take, ex_wb, ex_load, ex_store;
    status_t     ex_status;
    logic [3:0]  st_en;
    logic [31:0] st_data;
    logic [1:0]  off;

    assign a = valid_reg[inst_reg[19:15]] ? rf_q1 : '0;
    assign b = valid_reg[inst_reg[24:20]] ? rf_q2 : '0;

    always_comb begin
        opc    = inst_reg[6:0];
        rd     = inst_reg[11:7];
        f3     = inst_reg[14:12];
        f7     = inst_reg[31:25];
        immi   = {{20{inst_reg[31]}}, inst_reg[31:20]};
        imms   = {{20{inst_reg[31]}}, inst_reg[31:25], inst_reg[11:7]};
        immb   = {{19{inst_reg[31]}}, inst_reg[31], inst_reg[7], inst_reg[30:25],
                  inst_reg[11:8], 1'b0};
        immj   = {{11{inst_reg[31]}}, inst_reg[31], inst_reg[19:12], inst_reg[20],
                  inst_reg[30:21], 1'b0};
        immu   = {inst_reg[31:12], 12'b0};
        pc4    = pc_reg + 32'd4;
        sum_ai = a + immi;
        op2    = (opc == OPC_OP || opc == OPC_BRANCH) ? b : immi;
        sh     = (opc == OPC_OP) ? b[4:0] : inst_reg[24:20];
        lt_s   = $signed(a) < $signed(op2);
        lt_u   = a < op2;

        unique case (f3)
            3'd0:    alu = (opc == OPC_OP && f7 == F7_ALT) ? a - b : a + op2;
            3'd1:    alu = a << sh;
            3'd2:    alu = {31'b0, lt_s};
            3'd3:    alu = {31'b0, lt_u};
            3'd4:    alu = a ^ op2;
            3'd5:    alu = f7[5] ? 32'($signed(a) >>> sh) : a >> sh;
            3'd6:    alu = a | op2;
            default: alu = a & op2;
        endcase

        unique case (f3)
            3'd0:    take = (a == b);
            3'd1:    take = (a != b);
            3'd4:    take = lt_s;
            3'd5:    take = !lt_s;
            3'd6:    take = lt_u;
            default: take = !lt_u;
        endcase

        sz       = f3[1:0];
        mem_addr = (opc == OPC_STORE) ? a + imms : sum_ai;
        mem_end  = {1'b0, mem_addr} + (33'd1 << sz);

        ex_status  = STS_OK;
        ex_wb      = 1'b0;
        ex_val     = alu;
        ex_next_pc = pc4;
        ex_load    = 1'b0;
        ex_store   = 1'b0;

        unique case (opc)
            OPC_LUI: begin
                ex_wb  = 1'b1;
                ex_val = immu;
            end
            OPC_AUIPC: begin
                ex_wb  = 1'b1;
                ex_val = immu + pc_reg;
            end
            OPC_JAL: begin
                ex_wb      = 1'b1;
                ex_val     = pc4;
                ex_next_pc = pc_reg + immj;
            end
            OPC_JALR: begin
                if (f3 != 3'd0) begin
                    ex_status = STS_ILLEGAL;
                end else begin
                    ex_wb      = 1'b1;
                    ex_val     = pc4;
                    ex_next_pc = {sum_ai[31:1], 1'b0};
                end
            end
            OPC_BRANCH: begin
                if (f3 == 3'd2 || f3 == 3'd3) begin
                    ex_status = STS_ILLEGAL;
                end else if (take) begin
                    ex_next_pc = pc_reg + immb;
                end
            end
            OPC_LOAD, OPC_STORE: begin
                if ((opc == OPC_LOAD && (f3 == 3'd3 || f3 > 3'd5)) ||
                    (opc == OPC_STORE && f3 > 3'd2)) begin
                    ex_status = STS_ILLEGAL;
                end else if (mem_end > 33'(MEM_BYTES)) begin
                    ex_status = STS_ACCESS;
                end else if ((sz == 2'd1 && mem_addr[0]) ||
                             (sz == 2'd2 && mem_addr[1:0] != 2'd0)) begin
                    ex_status = STS_MISALIGN;
                end else begin
                    ex_load  = (opc == OPC_LOAD);
                    ex_store = (opc == OPC_STORE);
                end
            end
            OPC_OPIMM: begin
                if ((f3 == 3'd1 && f7 != F7_BASE) ||
                    (f3 == 3'd5 && f7 != F7_BASE && f7 != F7_ALT)) begin
                    ex_status = STS_ILLEGAL;
                end else begin
                    ex_wb = 1'b1;
                end
            end
            OPC_OP: begin
                if (f7 == F7_BASE || (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) begin
                    ex_wb = 1'b1;
                end else begin
                    ex_status = STS_ILLEGAL;
                end
            end
            default: ex_status = STS_ILLEGAL;
        endcase

        for (int i = 0; i < 4; i++) begin
            off      = 2'(i) - mem_addr[1:0];
            st_en[i] = (sz == 2'd2) || (sz == 2'd1 && off < 2'd2) || (sz == 2'd0 && off == 2'd0);
            st_data[8*i +: 8] = b[{off, 3'b000} +: 8];
        end
    end

    // lane read rows: byte k of the word at base sits in lane (base + k) mod 4
    logic [31:0] rd_base;
    logic [31:0] rd_sum [4];
    logic [1:0]  rd_off [4];

    always_comb begin
        rd_base = (state_reg == S_EXEC) ? mem_addr : pc_reg;
        for (int i = 0; i < 4; i++) begin
            rd_off[i]     = 2'(i) - rd_base[1:0];
            rd_sum[i]     = rd_base + {30'b0, rd_off[i]};
            lane_raddr[i] = rd_sum[i][RW+1:2];
        end
    end

    logic        out_free;
    logic        res_fire;
    status_t     res_status;
    logic        wb_en;
    logic [4:0]  wb_idx;
    logic [31:0] wb_val;
    logic [31:0] fetched;
    logic [31:0] ld_word;
    logic [31:0] ld_val;
    logic [31:0] la32;

    assign out_free  = !res_valid_reg || m_ready;
    assign fetched   = gather_bytes(pc_reg[1:0], lanes_q);
    assign ld_word   = gather_bytes(ld_lo_reg, lanes_q);
    assign la32      = {16'b0, item.addr};
    assign accept_en = (state_reg != S_CLEAR);

    always_comb begin
        unique case (ld_f3_reg)
            3'd0:    ld_val = {{24{ld_word[7]}}, ld_word[7:0]};
            3'd1:    ld_val = {{16{ld_word[15]}}, ld_word[15:0]};
            3'd4:    ld_val = {24'b0, ld_word[7:0]};
            3'd5:    ld_val = {16'b0, ld_word[15:0]};
            default: ld_val = ld_word;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        stopped_next   = stopped_reg;
        clr_next       = clr_reg;
        inst_next      = inst_reg;
        valid_next     = valid_reg;
        x10_next       = x10_reg;
        ld_f3_next     = ld_f3_reg;
        ld_lo_next     = ld_lo_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !m_ready;
        item_pop       = 1'b0;
        res_fire       = 1'b0;
        res_status     = STS_OK;
        wb_en          = 1'b0;
        wb_idx         = rd;
        wb_val         = ex_val;
        rf_ra1         = fetched[19:15];
        rf_ra2         = fetched[24:20];
        for (int i = 0; i < 4; i++) begin
            lane_we[i]    = 1'b0;
            lane_waddr[i] = mem_addr[RW+1:2];
            lane_wdata[i] = st_data[8*i +: 8];
        end

        unique case (state_reg)
            S_CLEAR: begin
                for (int i = 0; i < 4; i++) begin
                    lane_we[i]    = 1'b1;
                    lane_waddr[i] = clr_reg;
                    lane_wdata[i] = 8'h00;
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == RW'(ROWS-1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (item_valid && out_free) begin
                    item_pop = 1'b1;
                    if (!item.is_step) begin
                        res_fire = 1'b1;
                        if (la32 < 32'(MEM_BYTES)) begin
                            for (int i = 0; i < 4; i++) begin
                                lane_we[i]    = (item.addr[1:0] == 2'(i));
                                lane_waddr[i] = la32[RW+1:2];
                                lane_wdata[i] = item.data;
                            end
                        end
                    end else if (stopped_reg) begin
                        res_fire   = 1'b1;
                        res_status = STS_STOPPED;
                    end else if ({1'b0, pc_reg} + 33'd3 >= 33'(MEM_BYTES)) begin
                        res_fire     = 1'b1;
                        res_status   = STS_PC_RANGE;
                        stopped_next = 1'b1;
                    end else begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                inst_next = fetched;
                if (fetched == halt_word) begin
                    res_fire     = 1'b1;
                    res_status   = STS_HALT;
                    stopped_next = 1'b1;
                    state_next   = S_IDLE;
                end else begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (ex_status != STS_OK) begin
                    res_fire     = 1'b1;
                    res_status   = ex_status;
                    stopped_next = 1'b1;
                    pc_next      = pc4;
                    state_next   = S_IDLE;
                end else if (ex_load) begin
                    ld_f3_next = f3;
                    ld_lo_next = mem_addr[1:0];
                    state_next = S_LOADWB;
                end else begin
                    if (ex_store) begin
                        for (int i = 0; i < 4; i++) begin
                            lane_we[i] = st_en[i];
                        end
                    end
                    wb_en      = ex_wb;
                    res_fire   = 1'b1;
                    pc_next    = ex_next_pc;
                    state_next = S_IDLE;
                end
            end
            S_LOADWB: begin
                wb_en      = 1'b1;
                wb_val     = ld_val;
                res_fire   = 1'b1;
                pc_next    = pc4;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        wb_en    = wb_en && (wb_idx != 5'd0);
        rf_we    = wb_en;
        rf_waddr = wb_idx;
        rf_wdata = wb_val;
        if (wb_en) begin
            valid_next[wb_idx] = 1'b1;
            if (wb_idx == 5'd10) begin
                x10_next = wb_val[7:0];
            end
        end

        if (res_fire) begin
            res_valid_next = 1'b1;
            res_next = '{status:    res_status,
                         pc_after:  pc_next,
                         reg_write: wb_en,
                         reg_index: wb_en ? wb_idx : 5'd0,
                         reg_value: wb_en ? wb_val : 32'd0,
                         exit_code: x10_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            pc_reg        <= '0;
            stopped_reg   <= 1'b0;
            clr_reg       <= '0;
            valid_reg     <= '0;
            x10_reg       <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            stopped_reg   <= stopped_next;
            clr_reg       <= clr_next;
            valid_reg     <= valid_next;
            x10_reg       <= x10_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        inst_reg  <= inst_next;
        ld_f3_reg <= ld_f3_next;
        ld_lo_reg <= ld_lo_next;
        res_reg   <= res_next;
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

    `RVS_ASSERT_IMPL(a_res_slot_free, res_fire, !res_valid_reg || m_ready, "result overwrites a waiting beat")
    `RVS_ASSERT_NEXT(a_stop_sticky, stopped_reg, stopped_reg, "stop flag dropped")
    `RVS_ASSERT_HOLDS(a_x0_unwritten, !valid_reg[0], "x0 marked written")
    `RVS_ASSERT_IMPL(a_no_pop_clearing, state_reg == S_CLEAR, !item_pop, "item taken during clear")
endmodule
